FILE: hdl/vmf_pkg.sv
// vmf_pkg: constants, register indexes, direction codes and shared types
// for the six-neighbor majority fill block. No dependencies.
package vmf_pkg;

	localparam int MAX_X     = 256;
	localparam int MAX_Y     = 256;
	localparam int X_W       = $clog2(MAX_X);
	localparam int Y_W       = $clog2(MAX_Y);
	localparam int DEPTH     = 2 * MAX_X * MAX_Y;
	localparam int ADDR_W    = $clog2(DEPTH);

	localparam int LABEL_W   = 32;
	localparam int SIZE_XY_W = 9;
	localparam int SIZE_Z_W  = 16;
	localparam int FC_W      = 31;
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 3;
	localparam int DIR_W     = 3;
	localparam int NUM_NB    = 6;
	localparam int CNT_W     = 32;
	localparam int VOTE_W    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_EN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FC    = 3'd4;

	localparam logic REQ_LABEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	localparam logic [DIR_W-1:0] DIR_MZ   = 3'd0;
	localparam logic [DIR_W-1:0] DIR_MY   = 3'd1;
	localparam logic [DIR_W-1:0] DIR_MX   = 3'd2;
	localparam logic [DIR_W-1:0] DIR_PX   = 3'd3;
	localparam logic [DIR_W-1:0] DIR_PY   = 3'd4;
	localparam logic [DIR_W-1:0] DIR_PZ   = 3'd5;
	localparam logic [DIR_W-1:0] DIR_NONE = 3'd6;

	typedef logic [LABEL_W-1:0] label_t;
	typedef logic [ADDR_W-1:0]  addr_t;

	// neighbor labels and center of one decided voxel, indexed by direction
	typedef struct packed {
		logic [NUM_NB-1:0]          has_nb;
		label_t [NUM_NB-1:0]        nb;
		label_t                     orig;
		logic                       last;
	} cand_t;

endpackage

FILE: hdl/vmf_if.sv
// Valid/ready channels of the majority fill block: voxel words in, results out.
// Depends on vmf_pkg.
interface vmf_in_if;
	import vmf_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic signed [LABEL_W-1:0] label_in;

	modport source(output valid, output req_type, output label_in, input ready);
	modport sink(input valid, input req_type, input label_in, output ready);
endinterface

interface vmf_out_if;
	import vmf_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [LABEL_W-1:0] label_out;
	logic [DIR_W-1:0]          source_dir;
	logic                      was_bad;
	logic                      out_of_range;
	logic [CNT_W-1:0]          bad_total;
	logic [CNT_W-1:0]          fillable_total;
	logic                      last;

	modport source(output valid, output label_out, output source_dir, output was_bad,
		output out_of_range, output bad_total, output fillable_total, output last,
		input ready);
	modport sink(input valid, input label_out, input source_dir, input was_bad,
		input out_of_range, input bad_total, input fillable_total, input last,
		output ready);
endinterface

FILE: hdl/vmf_ram.sv
// vmf_ram: two-slice label store, one write port and two registered read ports.
// Read during write to the same entry returns the old word. Depends on vmf_pkg.
module vmf_ram (
	input  logic                 clk,
	input  logic                 we,
	input  vmf_pkg::addr_t       waddr,
	input  vmf_pkg::label_t      wdata,
	input  logic                 re,
	input  vmf_pkg::addr_t       raddr_a,
	input  vmf_pkg::addr_t       raddr_b,
	output vmf_pkg::label_t      rdata_a,
	output vmf_pkg::label_t      rdata_b
);
	import vmf_pkg::*;

	label_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: hdl/vmf_vote.sv
// vmf_vote: neighbor vote (compare stage, count and select stage), pass
// counters and the output register. Depends on vmf_pkg and vmf_if.
module vmf_vote (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cand_valid,
	output logic                      cand_ready,
	input  vmf_pkg::cand_t            cand,
	input  logic                      check_enable,
	input  logic [vmf_pkg::FC_W-1:0]  max_fc,
	input  logic                      restart,
	vmf_out_if.source                 result
);
	import vmf_pkg::*;

	logic                            v_s2;
	label_t [NUM_NB-1:0]             nb_s2;
	logic [NUM_NB-1:0]               vote_s2;
	logic [NUM_NB-1:0][NUM_NB-1:0]   eq_s2;
	label_t                          orig_s2;
	logic                            bad_s2;
	logic                            oor_s2;
	logic                            last_s2;

	logic [NUM_NB-1:0]               vote_c;
	logic [NUM_NB-1:0][NUM_NB-1:0]   eq_c;
	logic                            bad_c;
	logic                            oor_c;

	logic [VOTE_W-1:0]               pc [NUM_NB];
	logic [VOTE_W-1:0]               best;
	logic [DIR_W-1:0]                win;
	logic                            found;
	label_t                          label_c;
	logic [DIR_W-1:0]                dir_c;
	logic [CNT_W-1:0]                bad_next;
	logic [CNT_W-1:0]                fill_next;

	logic                            out_v_q;
	label_t                          label_q;
	logic [DIR_W-1:0]                dir_q;
	logic                            was_bad_q;
	logic                            oor_q;
	logic [CNT_W-1:0]                bad_cnt_q;
	logic [CNT_W-1:0]                fill_cnt_q;
	logic [CNT_W-1:0]                bad_tot_q;
	logic [CNT_W-1:0]                fill_tot_q;
	logic                            last_q;

	logic                            out_rdy;
	logic                            s2_rdy;
	logic                            out_load;

	assign out_rdy    = !out_v_q || result.ready;
	assign s2_rdy     = !v_s2 || out_rdy;
	assign cand_ready = s2_rdy;
	assign out_load   = v_s2 && out_rdy;

	// compare stage: which neighbors vote and which earlier ones match
	always_comb begin
		for (int i = 0; i < NUM_NB; i++) begin
			vote_c[i] = cand.has_nb[i] && !cand.nb[i][LABEL_W-1];
			for (int j = 0; j < NUM_NB; j++) begin
				eq_c[i][j] = (j < i) && (cand.nb[i] == cand.nb[j]);
			end
		end
		bad_c = cand.orig[LABEL_W-1];
		oor_c = check_enable && !bad_c && (cand.orig[FC_W-1:0] >= max_fc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_rdy) begin
			v_s2 <= cand_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cand_valid && s2_rdy) begin
			nb_s2   <= cand.nb;
			vote_s2 <= vote_c;
			eq_s2   <= eq_c;
			orig_s2 <= cand.orig;
			bad_s2  <= bad_c;
			oor_s2  <= oor_c;
			last_s2 <= cand.last;
		end
	end

	// winner: earliest neighbor whose running count reaches the overall maximum
	always_comb begin
		logic [VOTE_W-1:0] acc;
		acc  = '0;
		best = '0;
		win  = DIR_NONE;
		for (int i = 0; i < NUM_NB; i++) begin
			acc = '0;
			if (vote_s2[i]) begin
				acc = VOTE_W'(1);
				for (int j = 0; j < i; j++) begin
					acc = acc + VOTE_W'(vote_s2[j] && eq_s2[i][j]);
				end
			end
			pc[i] = acc;
		end
		for (int i = 0; i < NUM_NB; i++) begin
			if (pc[i] > best) begin
				best = pc[i];
			end
		end
		for (int i = NUM_NB - 1; i >= 0; i--) begin
			if (vote_s2[i] && (pc[i] == best)) begin
				win = DIR_W'(i);
			end
		end
		found   = bad_s2 && (|vote_s2);
		dir_c   = found ? win : DIR_NONE;
		label_c = found ? nb_s2[win] : orig_s2;
		bad_next  = (bad_s2 && (bad_cnt_q != '1)) ? bad_cnt_q + 1'b1 : bad_cnt_q;
		fill_next = (found && (fill_cnt_q != '1)) ? fill_cnt_q + 1'b1 : fill_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q    <= 1'b0;
			bad_cnt_q  <= '0;
			fill_cnt_q <= '0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
			priority if (restart) begin
				bad_cnt_q  <= '0;
				fill_cnt_q <= '0;
			end else if (out_load && last_s2) begin
				bad_cnt_q  <= '0;
				fill_cnt_q <= '0;
			end else if (out_load) begin
				bad_cnt_q  <= bad_next;
				fill_cnt_q <= fill_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			label_q    <= label_c;
			dir_q      <= dir_c;
			was_bad_q  <= bad_s2;
			oor_q      <= oor_s2;
			bad_tot_q  <= bad_next;
			fill_tot_q <= fill_next;
			last_q     <= last_s2;
		end
	end

	assign result.valid          = out_v_q;
	assign result.label_out      = $signed(label_q);
	assign result.source_dir     = dir_q;
	assign result.was_bad        = was_bad_q;
	assign result.out_of_range   = oor_q;
	assign result.bad_total      = bad_tot_q;
	assign result.fillable_total = fill_tot_q;
	assign result.last           = last_q;

endmodule

FILE: hdl/voxel_six_neighbor_majority_fill.sv
// Top level of the six-neighbor majority fill: configuration, raster position,
// three copies of the two-slice store and the vote pipeline.
// Pipeline: registered store reads, then registered compare results, then the output register.
// Throughput: one word per cycle while the result channel does not stall; three store
// copies with two read ports each supply the five stored neighbors and the center together.
// Reset: positions, counters, configuration and valid flags to defaults; store contents and data registers undefined.
module voxel_six_neighbor_majority_fill (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [vmf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vmf_pkg::CFG_W-1:0]     cfg_data,
	vmf_in_if.sink                        voxel,
	vmf_out_if.source                     result
);
	import vmf_pkg::*;

	logic [SIZE_XY_W-1:0] size_x_q;
	logic [SIZE_XY_W-1:0] size_y_q;
	logic [SIZE_Z_W-1:0]  size_z_q;
	logic                 check_en_q;
	logic [FC_W-1:0]      max_fc_q;

	logic [X_W-1:0]       pos_x_q;
	logic [Y_W-1:0]       pos_y_q;
	logic [SIZE_Z_W-1:0]  pos_z_q;

	logic [SIZE_XY_W-1:0] sx;
	logic [SIZE_XY_W-1:0] sy;
	logic [SIZE_Z_W-1:0]  sz;
	logic                 restart;
	logic                 accept;
	logic                 is_label;
	logic                 wr;
	logic                 drain_hit;
	logic                 dec;
	logic                 x_end;
	logic                 y_end;
	logic                 last_c;
	logic                 cur;
	logic [NUM_NB-1:0]    has_c;

	addr_t                a_mz, a_my, a_mx, a_px, a_py, a_c;
	label_t               rd_mz, rd_my, rd_mx, rd_px, rd_py, rd_c;

	logic                 v_s1;
	logic [NUM_NB-1:0]    has_s1;
	label_t               up_s1;
	logic                 last_s1;
	logic                 cand_ready;
	cand_t                cand;

	function automatic addr_t addr_of(input logic par, input logic [Y_W-1:0] y,
		input logic [X_W-1:0] x);
		return ADDR_W'(par) * ADDR_W'(MAX_X * MAX_Y) + ADDR_W'(y) * ADDR_W'(MAX_X)
			+ ADDR_W'(x);
	endfunction

	assign restart = cfg_wr_en && ((cfg_index == REG_SIZE_X) || (cfg_index == REG_SIZE_Y)
		|| (cfg_index == REG_SIZE_Z));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q   <= SIZE_XY_W'(1);
			size_y_q   <= SIZE_XY_W'(1);
			size_z_q   <= SIZE_Z_W'(1);
			check_en_q <= 1'b0;
			max_fc_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SIZE_X:   size_x_q   <= cfg_data[SIZE_XY_W-1:0];
				REG_SIZE_Y:   size_y_q   <= cfg_data[SIZE_XY_W-1:0];
				REG_SIZE_Z:   size_z_q   <= cfg_data[SIZE_Z_W-1:0];
				REG_CHECK_EN: check_en_q <= cfg_data[0];
				REG_MAX_FC:   max_fc_q   <= cfg_data[FC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (size_x_q == '0) sx = SIZE_XY_W'(1);
		else if (size_x_q > SIZE_XY_W'(MAX_X)) sx = SIZE_XY_W'(MAX_X);
		else sx = size_x_q;
		priority if (size_y_q == '0) sy = SIZE_XY_W'(1);
		else if (size_y_q > SIZE_XY_W'(MAX_Y)) sy = SIZE_XY_W'(MAX_Y);
		else sy = size_y_q;
		sz = (size_z_q == '0) ? SIZE_Z_W'(1) : size_z_q;
	end

	assign voxel.ready = !v_s1 || cand_ready;
	assign accept      = voxel.valid && voxel.ready;

	always_comb begin
		is_label  = (voxel.req_type == REQ_LABEL);
		wr        = is_label && (pos_z_q < sz);
		drain_hit = !is_label && (pos_z_q == sz);
		dec       = (wr && (pos_z_q != '0)) || drain_hit;
		x_end     = ({1'b0, pos_x_q} + SIZE_XY_W'(1)) >= sx;
		y_end     = ({1'b0, pos_y_q} + SIZE_XY_W'(1)) >= sy;
		last_c    = drain_hit && x_end && y_end;
		cur       = ~pos_z_q[0];
		has_c         = '0;
		has_c[DIR_MZ] = pos_z_q > SIZE_Z_W'(1);
		has_c[DIR_MY] = pos_y_q != '0;
		has_c[DIR_MX] = pos_x_q != '0;
		has_c[DIR_PX] = !x_end;
		has_c[DIR_PY] = !y_end;
		has_c[DIR_PZ] = is_label;
		a_mz = addr_of(pos_z_q[0], pos_y_q, pos_x_q);
		a_my = addr_of(cur, pos_y_q - 1'b1, pos_x_q);
		a_mx = addr_of(cur, pos_y_q, pos_x_q - 1'b1);
		a_px = addr_of(cur, pos_y_q, pos_x_q + 1'b1);
		a_py = addr_of(cur, pos_y_q + 1'b1, pos_x_q);
		a_c  = addr_of(cur, pos_y_q, pos_x_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (restart || (accept && last_c)) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (accept && (wr || drain_hit)) begin
			if (x_end) begin
				pos_x_q <= '0;
				if (y_end) begin
					pos_y_q <= '0;
					pos_z_q <= pos_z_q + 1'b1;
				end else begin
					pos_y_q <= pos_y_q + 1'b1;
				end
			end else begin
				pos_x_q <= pos_x_q + 1'b1;
			end
		end
	end

	// -z neighbor shares its entry with the word being written: read returns old data
	vmf_ram u_ram_a (
		.clk     (clk),
		.we      (accept && wr),
		.waddr   (a_mz),
		.wdata   ($unsigned(voxel.label_in)),
		.re      (accept && dec),
		.raddr_a (a_mz),
		.raddr_b (a_c),
		.rdata_a (rd_mz),
		.rdata_b (rd_c)
	);

	vmf_ram u_ram_b (
		.clk     (clk),
		.we      (accept && wr),
		.waddr   (a_mz),
		.wdata   ($unsigned(voxel.label_in)),
		.re      (accept && dec),
		.raddr_a (a_my),
		.raddr_b (a_mx),
		.rdata_a (rd_my),
		.rdata_b (rd_mx)
	);

	vmf_ram u_ram_c (
		.clk     (clk),
		.we      (accept && wr),
		.waddr   (a_mz),
		.wdata   ($unsigned(voxel.label_in)),
		.re      (accept && dec),
		.raddr_a (a_px),
		.raddr_b (a_py),
		.rdata_a (rd_px),
		.rdata_b (rd_py)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (voxel.ready) begin
			v_s1 <= accept && dec;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && dec) begin
			has_s1  <= has_c;
			up_s1   <= $unsigned(voxel.label_in);
			last_s1 <= last_c;
		end
	end

	always_comb begin
		cand.has_nb     = has_s1;
		cand.nb         = '0;
		cand.nb[DIR_MZ] = rd_mz;
		cand.nb[DIR_MY] = rd_my;
		cand.nb[DIR_MX] = rd_mx;
		cand.nb[DIR_PX] = rd_px;
		cand.nb[DIR_PY] = rd_py;
		cand.nb[DIR_PZ] = up_s1;
		cand.orig       = rd_c;
		cand.last       = last_s1;
	end

	vmf_vote u_vote (
		.clk          (clk),
		.arst_n       (arst_n),
		.cand_valid   (v_s1),
		.cand_ready   (cand_ready),
		.cand         (cand),
		.check_enable (check_en_q),
		.max_fc       (max_fc_q),
		.restart      (restart),
		.result       (result)
	);

endmodule
